>>> sv/ppe_pkg.sv
// Shared types, constants and helper functions for the palette pixel expander.
// No dependencies; every other file of the block but ppe_ram refers to this package.
package ppe_pkg;

  // fixed field widths
  localparam int ADDR_W     = 25;
  localparam int CFG_W      = 11;
  localparam int COLOR_W    = 30;
  localparam int COMP_W     = 10;
  localparam int BYTE_W     = 8;
  localparam int SLOT_W     = 4;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // parameter defaults
  localparam int DEF_PALETTE_ENTRIES = 16;
  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_MAX_HEIGHT      = 1024;

  // register reset values
  localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd320;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd200;

  // component full scale and byte full scale
  localparam logic [COMP_W-1:0] COMP_MAX  = 10'h3FF;
  localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;

  // bytes per target pixel
  localparam logic [2:0] BPP_RGB  = 3'd3;
  localparam logic [2:0] BPP_ARGB = 3'd4;

  // register word indexes
  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_WIDEN      = 3'd2,
    REG_C64        = 3'd3,
    REG_ALPHA      = 3'd4
  } reg_idx_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             widen;
    logic             c64;
    logic             alpha;
  } cfg_t;

  // pixel item waiting for its palette read data
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } pix_t;

  // copies minus one: 0, 1 or 3
  function automatic logic [1:0] copies_m1(input cfg_t cfg);
    return {cfg.widen & cfg.c64, cfg.widen | cfg.c64};
  endfunction

  // log2 of the copy count
  function automatic logic [1:0] copies_log2(input cfg_t cfg);
    return {1'b0, cfg.widen} + {1'b0, cfg.c64};
  endfunction

  // byte count of one target pixel
  function automatic logic [2:0] pixel_bytes(input cfg_t cfg);
    return cfg.alpha ? BPP_ARGB : BPP_RGB;
  endfunction

  // v*255/1023 truncated: q0 = p>>10, remainder p - q0*1023 stays below 2*1023
  function automatic logic [BYTE_W-1:0] scale_comp(input logic [COMP_W-1:0] v);
    logic [17:0] prod;
    logic [7:0]  q0;
    logic [10:0] rem;
    prod = {v, 8'b0} - {8'b0, v};
    q0   = prod[17:10];
    rem  = {1'b0, prod[9:0]} + {3'b0, q0};
    return (rem >= {1'b0, COMP_MAX}) ? q0 + 8'd1 : q0;
  endfunction

endpackage

>>> sv/ppe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ppe_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ppe_scan.sv
// Raster position tracker: column, row and row base address, and the
// pixel stage that waits on the palette read. Depends on ppe_pkg.
module ppe_scan #(
  parameter int MAX_WIDTH  = ppe_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ppe_pkg::DEF_MAX_HEIGHT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppe_pkg::cfg_t cfg_i,
  input  logic          pix_acc_i,
  input  logic          hit_i,
  input  logic          take_i,
  output ppe_pkg::pix_t pix_o
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CWW = (WW > ppe_pkg::CFG_W) ? WW : ppe_pkg::CFG_W;
  localparam int CHW = (HW > ppe_pkg::CFG_W) ? HW : ppe_pkg::CFG_W;
  localparam int AW  = ppe_pkg::ADDR_W;

  logic [XW-1:0]  col_q, col_d;
  logic [YW-1:0]  row_q, row_d;
  logic [AW-1:0]  base_q, base_d;
  logic           valid_q;
  logic           hit_q;
  logic [AW-1:0]  addr_q;

  logic [CWW-1:0] w_raw;
  logic [CHW-1:0] h_raw;
  logic [WW-1:0]  w_clamp;
  logic [HW-1:0]  h_clamp;
  logic [WW-1:0]  col_inc;
  logic [HW-1:0]  row_inc;
  logic           col_wrap;
  logic           row_wrap;
  logic [AW-1:0]  col_ext;
  logic [AW-1:0]  col_bytes;
  logic [AW-1:0]  w_ext;
  logic [AW-1:0]  w_bytes;
  logic [AW-1:0]  addr0;
  logic [AW-1:0]  stride;
  logic [1:0]     shamt;

  // clamp configured sizes into 1..max
  assign w_raw = CWW'(cfg_i.width);
  assign h_raw = CHW'(cfg_i.height);

  always_comb begin
    priority if (w_raw == '0) begin
      w_clamp = WW'(1);
    end else if (w_raw > CWW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(w_raw);
    end
  end

  always_comb begin
    priority if (h_raw == '0) begin
      h_clamp = HW'(1);
    end else if (h_raw > CHW'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(h_raw);
    end
  end

  // wrap detection
  assign col_inc  = WW'(col_q) + WW'(1);
  assign row_inc  = HW'(row_q) + HW'(1);
  assign col_wrap = (col_inc >= w_clamp);
  assign row_wrap = (row_inc >= h_clamp);

  // byte offsets: times 3 or 4 by shift and add, then times the copy count; the row stride doubles again in c64 mode
  assign shamt     = ppe_pkg::copies_log2(cfg_i);
  assign col_ext   = AW'(col_q);
  assign col_bytes = cfg_i.alpha ? (col_ext << 2) : ((col_ext << 1) + col_ext);
  assign addr0     = base_q + (col_bytes << shamt);
  assign w_ext     = AW'(w_clamp);
  assign w_bytes   = cfg_i.alpha ? (w_ext << 2) : ((w_ext << 1) + w_ext);
  assign stride    = w_bytes << ({1'b0, shamt} + {2'b0, cfg_i.c64});

  // next position after a pixel item
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    if (pix_acc_i) begin
      if (col_wrap) begin
        col_d = '0;
        if (row_wrap) begin
          row_d  = '0;
          base_d = '0;
        end else begin
          row_d  = YW'(row_inc);
          base_d = base_q + stride;
        end
      end else begin
        col_d = XW'(col_inc);
      end
    end
  end

  // position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

  // pixel stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      priority if (pix_acc_i) begin
        valid_q <= 1'b1;
      end else if (take_i) begin
        valid_q <= 1'b0;
      end else begin
        valid_q <= valid_q;
      end
    end
  end

  // pixel stage payload
  always_ff @(posedge clk_i) begin
    if (pix_acc_i) begin
      hit_q  <= hit_i;
      addr_q <= addr0;
    end
  end

  assign pix_o.valid = valid_q;
  assign pix_o.hit   = hit_q;
  assign pix_o.addr  = addr_q;

endmodule

>>> sv/ppe_emit.sv
// Output stage: scales the palette color to bytes and replays it once per
// target copy with a stepping byte address. Depends on ppe_pkg.
module ppe_emit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ppe_pkg::cfg_t                        cfg_i,
  input  ppe_pkg::pix_t                        pix_i,
  input  logic [ppe_pkg::COLOR_W-1:0]          rdata_i,
  input  logic                                 out_stall_i,
  output logic                                 take_o,
  output logic                                 out_valid_o,
  output logic [ppe_pkg::ADDR_W-1:0]           byte_address_o,
  output logic [ppe_pkg::BYTE_W-1:0]           alpha_byte_o,
  output logic [ppe_pkg::BYTE_W-1:0]           red_byte_o,
  output logic [ppe_pkg::BYTE_W-1:0]           green_byte_o,
  output logic [ppe_pkg::BYTE_W-1:0]           blue_byte_o,
  output logic                                 last_copy_o
);

  localparam int AW = ppe_pkg::ADDR_W;
  localparam int BW = ppe_pkg::BYTE_W;
  localparam int CW = ppe_pkg::COMP_W;

  logic                             valid_q;
  logic [1:0]                       left_q;
  logic [AW-1:0]                    addr_q;
  logic [BW-1:0]                    red_q, green_q, blue_q;
  logic [ppe_pkg::COLOR_W-1:0]      color;
  logic                             last;
  logic                             out_acc;
  logic                             free;

  // handshake bookkeeping
  assign last    = (left_q == 2'd0);
  assign out_acc = valid_q & ~out_stall_i;
  assign free    = ~valid_q | (out_acc & last);
  assign take_o  = pix_i.valid & free;

  // indexes beyond the palette read as black
  assign color = pix_i.hit ? rdata_i : '0;

  // occupancy and copy counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= 2'd0;
    end else begin
      priority if (take_o) begin
        valid_q <= 1'b1;
        left_q  <= ppe_pkg::copies_m1(cfg_i);
      end else if (free) begin
        valid_q <= 1'b0;
      end else if (out_acc) begin
        left_q <= left_q - 2'd1;
      end else begin
        left_q <= left_q;
      end
    end
  end

  // payload: load a new pixel or step to the next copy
  always_ff @(posedge clk_i) begin
    priority if (take_o) begin
      addr_q  <= pix_i.addr;
      red_q   <= ppe_pkg::scale_comp(color[3*CW-1:2*CW]);
      green_q <= ppe_pkg::scale_comp(color[2*CW-1:CW]);
      blue_q  <= ppe_pkg::scale_comp(color[CW-1:0]);
    end else if (out_acc && !last) begin
      addr_q <= addr_q + AW'(ppe_pkg::pixel_bytes(cfg_i));
    end else begin
      addr_q <= addr_q;
    end
  end

  assign out_valid_o    = valid_q;
  assign byte_address_o = addr_q;
  assign alpha_byte_o   = cfg_i.alpha ? ppe_pkg::BYTE_FULL : '0;
  assign red_byte_o     = red_q;
  assign green_byte_o   = green_q;
  assign blue_byte_o    = blue_q;
  assign last_copy_o    = last;

endmodule

>>> sv/palette_pixel_expander.sv
// Palette pixel expander. An input item is either a palette write (action 1),
// which stores a packed 10-bit RGB color and yields no result, or a 4-bit
// pixel index (action 0), which yields 1, 2 or 4 target pixel items (widen
// and c64 modes) with scaled color bytes and a byte address. The copies of a
// pixel item leave through the single output port one after another, held
// while out_stall_i is high. The palette RAM read register and the pixel stage
// feed the output register that presents the first copy. One pixel can wait
// behind the output stage, so input is taken while a result is still pending.
// The palette holds no defined value until written. Registers sit on an APB
// port at word addresses 0 to 4.
// Depends on ppe_pkg, ppe_ram, ppe_scan and ppe_emit.
module palette_pixel_expander #(
  parameter int PALETTE_ENTRIES = ppe_pkg::DEF_PALETTE_ENTRIES,
  parameter int MAX_WIDTH       = ppe_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = ppe_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppe_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ppe_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ppe_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic [ppe_pkg::SLOT_W-1:0]         palette_slot_i,
  input  logic [ppe_pkg::COLOR_W-1:0]        color_word_i,
  input  logic [ppe_pkg::SLOT_W-1:0]         pixel_index_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ppe_pkg::ADDR_W-1:0]         byte_address_o,
  output logic [ppe_pkg::BYTE_W-1:0]         alpha_byte_o,
  output logic [ppe_pkg::BYTE_W-1:0]         red_byte_o,
  output logic [ppe_pkg::BYTE_W-1:0]         green_byte_o,
  output logic [ppe_pkg::BYTE_W-1:0]         blue_byte_o,
  output logic                               last_copy_o
);

  localparam int IW = $clog2(PALETTE_ENTRIES);
  localparam int SW = ppe_pkg::SLOT_W;
  localparam int CW = ppe_pkg::CFG_W;
  localparam int DW = ppe_pkg::APB_DATA_W;
  localparam int AW = ppe_pkg::ADDR_W;

  ppe_pkg::cfg_t      cfg_q, cfg_d;
  ppe_pkg::pix_t      pix;
  ppe_pkg::reg_idx_e  reg_idx;
  logic               cfg_we;
  logic               in_acc;
  logic               pix_acc;
  logic               slot_hit;
  logic               index_hit;
  logic               ram_we;
  logic               take;
  logic [ppe_pkg::COLOR_W-1:0] rdata;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = ppe_pkg::reg_idx_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (reg_idx)
        ppe_pkg::REG_SRC_WIDTH:  cfg_d.width  = pwdata[CW-1:0];
        ppe_pkg::REG_SRC_HEIGHT: cfg_d.height = pwdata[CW-1:0];
        ppe_pkg::REG_WIDEN:      cfg_d.widen  = pwdata[0];
        ppe_pkg::REG_C64:        cfg_d.c64    = pwdata[0];
        ppe_pkg::REG_ALPHA:      cfg_d.alpha  = pwdata[0];
        default:                 cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= ppe_pkg::RST_WIDTH;
      cfg_q.height <= ppe_pkg::RST_HEIGHT;
      cfg_q.widen  <= 1'b0;
      cfg_q.c64    <= 1'b0;
      cfg_q.alpha  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      ppe_pkg::REG_SRC_WIDTH:  prdata = DW'(cfg_q.width);
      ppe_pkg::REG_SRC_HEIGHT: prdata = DW'(cfg_q.height);
      ppe_pkg::REG_WIDEN:      prdata = DW'(cfg_q.widen);
      ppe_pkg::REG_C64:        prdata = DW'(cfg_q.c64);
      ppe_pkg::REG_ALPHA:      prdata = DW'(cfg_q.alpha);
      default:                 prdata = '0;
    endcase
  end

  // input handshake: stall only while the pixel stage is full and stuck
  assign in_stall_o = pix.valid & ~take;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign pix_acc    = in_acc & ~action_i;
  assign slot_hit   = ({{(32-SW){1'b0}}, palette_slot_i} < 32'(PALETTE_ENTRIES));
  assign index_hit  = ({{(32-SW){1'b0}}, pixel_index_i} < 32'(PALETTE_ENTRIES));
  assign ram_we     = in_acc & action_i & slot_hit;

  // palette store; a write always lands before any later read is issued
  ppe_ram #(
    .WIDTH (ppe_pkg::COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IW'(palette_slot_i)),
    .wdata_i (color_word_i),
    .re_i    (pix_acc),
    .raddr_i (IW'(pixel_index_i)),
    .rdata_o (rdata)
  );

  // raster position and pixel stage
  ppe_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .pix_acc_i (pix_acc),
    .hit_i     (index_hit),
    .take_i    (take),
    .pix_o     (pix)
  );

  // scaling and copy replay
  ppe_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pix_i          (pix),
    .rdata_i        (rdata),
    .out_stall_i    (out_stall_i),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .byte_address_o (byte_address_o),
    .alpha_byte_o   (alpha_byte_o),
    .red_byte_o     (red_byte_o),
    .green_byte_o   (green_byte_o),
    .blue_byte_o    (blue_byte_o),
    .last_copy_o    (last_copy_o)
  );

  // single copy mode never shows a non-final copy
  a_single_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cfg_q.widen && !cfg_q.c64) |-> last_copy_o)
    else $error("non-final copy with replication off");

  // a taken non-final copy is followed by the next copy one pixel further on
  a_copy_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_copy_o) |=>
      (out_valid_o &&
       byte_address_o == $past(byte_address_o) +
         (cfg_q.alpha ? AW'(ppe_pkg::BPP_ARGB) : AW'(ppe_pkg::BPP_RGB))))
    else $error("copy address did not advance by one target pixel");

  // a stalled input implies a full pixel stage
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pix.valid)
    else $error("input stalled with empty pixel stage");

  // a pixel stage move loads the output stage
  a_take_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("pixel taken but no result presented");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for palette_pixel_expander: palette writes and pixel items,
// with every target pixel checked against a local model of the expander.
// Depends on ppe_pkg and the palette_pixel_expander RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W     = ppe_pkg::ADDR_W;
  localparam int CFG_W      = ppe_pkg::CFG_W;
  localparam int COLOR_W    = ppe_pkg::COLOR_W;
  localparam int COMP_W     = ppe_pkg::COMP_W;
  localparam int BYTE_W     = ppe_pkg::BYTE_W;
  localparam int SLOT_W     = ppe_pkg::SLOT_W;
  localparam int APB_ADDR_W = ppe_pkg::APB_ADDR_W;
  localparam int APB_DATA_W = ppe_pkg::APB_DATA_W;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned QUIET_CYCLES = 8;
  localparam int unsigned PAL_DEPTH    = ppe_pkg::DEF_PALETTE_ENTRIES;
  localparam int unsigned WIDTH_CAP    = ppe_pkg::DEF_MAX_WIDTH;
  localparam int unsigned HEIGHT_CAP   = ppe_pkg::DEF_MAX_HEIGHT;
  localparam int unsigned REPORT_CAP   = 100;
  localparam logic [ADDR_W-1:0] ADDR_MASK = '1;

  typedef struct {
    logic               action;
    logic [SLOT_W-1:0]  slot;
    logic [COLOR_W-1:0] color;
    logic [SLOT_W-1:0]  index;
  } source_item_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              last;
  } target_pixel_t;

  // clock, reset and block ports
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  action_i       = 1'b0;
  logic [SLOT_W-1:0]     palette_slot_i = '0;
  logic [COLOR_W-1:0]    color_word_i   = '0;
  logic [SLOT_W-1:0]     pixel_index_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [ADDR_W-1:0]     byte_address_o;
  logic [BYTE_W-1:0]     alpha_byte_o;
  logic [BYTE_W-1:0]     red_byte_o;
  logic [BYTE_W-1:0]     green_byte_o;
  logic [BYTE_W-1:0]     blue_byte_o;
  logic                  last_copy_o;

  // model state: palette copy, raster position and register copy
  logic [COLOR_W-1:0] palette_copy [PAL_DEPTH];
  int unsigned        src_col;
  int unsigned        src_row;
  logic [ADDR_W-1:0]  row_base;
  logic [CFG_W-1:0]   cfg_width  = ppe_pkg::RST_WIDTH;
  logic [CFG_W-1:0]   cfg_height = ppe_pkg::RST_HEIGHT;
  logic               cfg_widen  = 1'b0;
  logic               cfg_c64    = 1'b0;
  logic               cfg_alpha  = 1'b0;

  source_item_t  pending_items [$];
  target_pixel_t expected_pixels [$];
  source_item_t  next_item;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned pixels_sent    = 0;
  int unsigned writes_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned settings_run   = 0;

  palette_pixel_expander dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .palette_slot_i (palette_slot_i),
    .color_word_i   (color_word_i),
    .pixel_index_i  (pixel_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_address_o (byte_address_o),
    .alpha_byte_o   (alpha_byte_o),
    .red_byte_o     (red_byte_o),
    .green_byte_o   (green_byte_o),
    .blue_byte_o    (blue_byte_o),
    .last_copy_o    (last_copy_o)
  );

  // free-running clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    // keep the log short once things go badly wrong
    if (error_count < REPORT_CAP) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  // 10-bit component to byte, truncating
  function automatic logic [BYTE_W-1:0] comp_to_byte(input logic [COMP_W-1:0] v);
    int unsigned full;
    full = (int'(v) * 255) / 1023;
    return full[BYTE_W-1:0];
  endfunction

  // apply one accepted item to the model, queue the target pixels it yields
  task automatic expand_item(input logic act, input logic [SLOT_W-1:0] slot,
                             input logic [COLOR_W-1:0] color,
                             input logic [SLOT_W-1:0] index);
    int unsigned   w, h, copies, bpp, stride, x;
    logic [COLOR_W-1:0] rgb;
    target_pixel_t px;
    if (act) begin
      palette_copy[slot] = color;
      writes_sent++;
    end else begin
      w      = clamp_size(cfg_width, WIDTH_CAP);
      h      = clamp_size(cfg_height, HEIGHT_CAP);
      copies = (cfg_widen ? 2 : 1) * (cfg_c64 ? 2 : 1);
      bpp    = cfg_alpha ? 4 : 3;
      rgb    = palette_copy[index];
      for (int unsigned k = 0; k < copies; k++) begin
        x        = src_col * copies + k;
        px.addr  = (row_base + x * bpp) & ADDR_MASK;
        px.alpha = cfg_alpha ? 8'hFF : 8'h00;
        px.red   = comp_to_byte(rgb[29:20]);
        px.green = comp_to_byte(rgb[19:10]);
        px.blue  = comp_to_byte(rgb[9:0]);
        px.last  = (k + 1 == copies);
        expected_pixels.push_back(px);
      end
      // advance the raster position, blank row skipped in c64 mode
      src_col++;
      if (src_col >= w) begin
        stride = w * copies * bpp * (cfg_c64 ? 2 : 1);
        src_col = 0;
        src_row++;
        row_base = (row_base + stride) & ADDR_MASK;
        if (src_row >= h) begin
          src_row  = 0;
          row_base = '0;
        end
      end
      pixels_sent++;
    end
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_error($sformatf("pixel %0d %s: got %0h, expected %0h",
                             pixels_checked, name, got, want));
    end
  endtask

  task automatic check_result();
    target_pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_error($sformatf("unexpected pixel at address %0h", byte_address_o));
    end else begin
      want = expected_pixels.pop_front();
      check_field("byte_address", byte_address_o, want.addr);
      check_field("alpha_byte", alpha_byte_o, want.alpha);
      check_field("red_byte", red_byte_o, want.red);
      check_field("green_byte", green_byte_o, want.green);
      check_field("blue_byte", blue_byte_o, want.blue);
      check_field("last_copy", last_copy_o, want.last);
    end
    pixels_checked++;
  endtask

  // input driver: present queued items, idle at random between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expand_item(action_i, palette_slot_i, color_word_i, pixel_index_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          action_i       <= next_item.action;
          palette_slot_i <= next_item.slot;
          color_word_i   <= next_item.color;
          pixel_index_i  <= next_item.index;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor with random stall and the run timeout
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
      end else begin
        if (out_valid_o && !out_stall_i) begin
          check_result();
        end
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // one register write: setup cycle then access cycle
  task automatic reg_write(input ppe_pkg::reg_idx_e idx,
                           input logic [APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait until every item is taken and every pixel has come out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_pixels.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [COMP_W-1:0] pick_comp();
    case ($urandom_range(3))
      0:       return '0;
      1:       return ppe_pkg::COMP_MAX;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  function automatic source_item_t random_item();
    source_item_t it;
    it.action = ($urandom_range(99) < 15);
    it.slot   = SLOT_W'($urandom);
    it.index  = SLOT_W'($urandom);
    if ($urandom_range(3) == 0) begin
      it.color = {pick_comp(), pick_comp(), pick_comp()};
    end else begin
      it.color = COLOR_W'($urandom);
    end
    return it;
  endfunction

  // one setting: registers, idling mix, then random items
  task automatic run_setting(input int unsigned w, input int unsigned h,
                             input logic widen, input logic c64, input logic alpha,
                             input int unsigned n_items, input int unsigned mix,
                             input bit hold_mid);
    wait_drained();
    reg_write(ppe_pkg::REG_SRC_WIDTH, APB_DATA_W'(w));
    reg_write(ppe_pkg::REG_SRC_HEIGHT, APB_DATA_W'(h));
    reg_write(ppe_pkg::REG_WIDEN, APB_DATA_W'(widen));
    reg_write(ppe_pkg::REG_C64, APB_DATA_W'(c64));
    reg_write(ppe_pkg::REG_ALPHA, APB_DATA_W'(alpha));
    cfg_width  = CFG_W'(w);
    cfg_height = CFG_W'(h);
    cfg_widen  = widen;
    cfg_c64    = c64;
    cfg_alpha  = alpha;
    case (mix % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
      default: begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
    settings_run++;
    for (int unsigned i = 0; i < n_items; i++) begin
      // sender holds off halfway until the block has emptied
      if (hold_mid && i == n_items / 2) wait_drained();
      pending_items.push_back(random_item());
    end
  endtask

  // stimulus
  initial begin
    source_item_t it;
    logic [COMP_W-1:0] levels [10];
    levels = '{10'd0, 10'd1, 10'd4, 10'd5, 10'd511, 10'd512, 10'd1018, 10'd1019,
               10'd1022, 10'd1023};
    src_col  = 0;
    src_row  = 0;
    row_base = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the whole palette with edge levels, black and white at the ends
    for (int unsigned s = 0; s < PAL_DEPTH; s++) begin
      it.action = 1'b1;
      it.slot   = SLOT_W'(s);
      it.index  = SLOT_W'(PAL_DEPTH - 1 - s);
      if (s == 0) begin
        it.color = '0;
      end else if (s == PAL_DEPTH - 1) begin
        it.color = '1;
      end else begin
        it.color = {levels[s % 10], levels[(s + 3) % 10], levels[(s + 7) % 10]};
      end
      pending_items.push_back(it);
    end
    // a few pixels under the reset geometry
    foreach (levels[i]) begin
      if (i < 4) begin
        it.action = 1'b0;
        it.slot   = SLOT_W'(i);
        it.color  = COLOR_W'($urandom);
        it.index  = (i == 0) ? '0 : (i == 1) ? '1 : SLOT_W'(5 * i);
        pending_items.push_back(it);
      end
    end

    // small pictures reach row and picture wrap quickly
    run_setting(1, 1, 1'b0, 1'b0, 1'b0, 40, 0, 1'b0);
    run_setting(3, 2, 1'b1, 1'b0, 1'b1, 40, 1, 1'b1);
    run_setting(4, 3, 1'b0, 1'b1, 1'b0, 40, 2, 1'b0);
    run_setting(2, 4, 1'b1, 1'b1, 1'b1, 40, 3, 1'b0);
    // zero sizes act as one
    run_setting(0, 0, 1'b1, 1'b1, 1'b0, 30, 0, 1'b0);
    // oversize saturates, then the largest legal size
    run_setting(2047, 2047, 1'b0, 1'b0, 1'b1, 30, 1, 1'b0);
    run_setting(1024, 1024, 1'b1, 1'b1, 1'b1, 30, 2, 1'b0);
    // shrink while the column is past the new width
    run_setting(5, 3, 1'b0, 1'b1, 1'b1, 40, 3, 1'b0);
    for (int unsigned p = 0; p < 3; p++) begin
      run_setting($urandom_range(1, 8), $urandom_range(1, 5), 1'($urandom),
                  1'($urandom), 1'($urandom), 40, p, 1'b0);
    end
    wait_drained();

    $display("covered %0d pixel items and %0d palette writes over %0d register settings",
             pixels_sent, writes_sent, settings_run);
    $display("%0d target pixels compared, %0d mismatches", pixels_checked, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
